@@ rtl/ptc_pkg.sv @@
// Shared types and constants for the pressure/temperature compensation pipeline.
`default_nettype none

package ptc_pkg;

  // Field widths
  localparam int RAW_W     = 24;  // raw conversion results
  localparam int CAL_W     = 16;  // factory calibration words
  localparam int DT_W      = 25;  // temperature difference, signed
  localparam int TEMP_W    = 20;  // working temperature, signed
  localparam int TOUT_W    = 19;  // temperature result field
  localparam int P_W       = 32;  // pressure result field
  localparam int TERM_W    = 40;  // offset and sensitivity, signed
  localparam int SQ_W      = 36;  // squared temperature deviations
  localparam int CORR_W    = 39;  // second-order offset/sensitivity terms
  localparam int CFG_IDX_W = 3;

  // Edges from an input transfer to its result strobe
  localparam int LATENCY = 10;

  // Calibration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_SLOPE      = 3'd5;

  // Temperature thresholds in hundredths of a degree
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -20'sd1500;

  // Calibration word set
  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coeff;
    logic [CAL_W-1:0] offset_temp_coeff;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_slope;
  } cal_t;

  // Hand-over from the correction stages to the pressure stages
  typedef struct packed {
    logic                     valid;
    logic [RAW_W-1:0]         d1;
    logic signed [TOUT_W-1:0] temp;
    logic signed [TERM_W-1:0] off;
    logic signed [TERM_W-1:0] sens;
  } front_t;

endpackage

`default_nettype wire

@@ rtl/ptc_cal_regs.sv @@
// Calibration word register file with its write channel.
`default_nettype none

module ptc_cal_regs import ptc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_data,
  output cal_t                 cal
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Register write; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRESSURE_SENSITIVITY:   cal.pressure_sensitivity   <= cfg_data;
        REG_PRESSURE_OFFSET:        cal.pressure_offset        <= cfg_data;
        REG_SENSITIVITY_TEMP_COEFF: cal.sensitivity_temp_coeff <= cfg_data;
        REG_OFFSET_TEMP_COEFF:      cal.offset_temp_coeff      <= cfg_data;
        REG_REFERENCE_TEMPERATURE:  cal.reference_temperature  <= cfg_data;
        REG_TEMPERATURE_SLOPE:      cal.temperature_slope      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptc_front.sv @@
// Temperature, first-order offset/sensitivity and second-order correction stages.
`default_nettype none

module ptc_front import ptc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [RAW_W-1:0] raw_temperature,
  input  cal_t             cal,
  output front_t           front
);

  // ---------------- stage 1: dT = D2 - C5*256
  logic signed [DT_W-1:0] dt_next;
  logic                   s1_valid;
  logic [RAW_W-1:0]       s1_d1;
  logic signed [DT_W-1:0] s1_dt;

  assign dt_next = $signed({1'b0, raw_temperature}) -
                   $signed({1'b0, cal.reference_temperature, 8'h00});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_d1 <= raw_pressure;
    s1_dt <= dt_next;
  end

  // ---------------- stage 2: the four products of dT
  logic               s2_valid;
  logic [RAW_W-1:0]   s2_d1;
  logic signed [41:0] s2_mt;
  logic signed [49:0] s2_mdd;
  logic signed [41:0] s2_moff;
  logic signed [41:0] s2_msens;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_d1    <= s1_d1;
    s2_mt    <= s1_dt * $signed({1'b0, cal.temperature_slope});
    s2_mdd   <= s1_dt * s1_dt;
    s2_moff  <= s1_dt * $signed({1'b0, cal.offset_temp_coeff});
    s2_msens <= s1_dt * $signed({1'b0, cal.sensitivity_temp_coeff});
  end

  // ---------------- stage 3: truncating scale-down, first-order terms
  logic signed [41:0]       mt_adj, mt_q;
  logic signed [41:0]       moff_adj, moff_q;
  logic signed [41:0]       msens_adj, msens_q;
  logic signed [TEMP_W-1:0] temp1_next;
  logic signed [TERM_W-1:0] off1_next, sens1_next;

  // negative values get a bias of divisor-1 so the shift rounds toward zero
  always_comb begin
    mt_adj     = s2_mt + (s2_mt[41] ? 42'sd8388607 : 42'sd0);
    mt_q       = mt_adj >>> 23;
    temp1_next = TEMP_BASE + $signed(mt_q[TEMP_W-1:0]);
    moff_adj   = s2_moff + (s2_moff[41] ? 42'sd127 : 42'sd0);
    moff_q     = moff_adj >>> 7;
    off1_next  = $signed({8'b0, cal.pressure_offset, 16'b0}) +
                 $signed(moff_q[TERM_W-1:0]);
    msens_adj  = s2_msens + (s2_msens[41] ? 42'sd255 : 42'sd0);
    msens_q    = msens_adj >>> 8;
    sens1_next = $signed({9'b0, cal.pressure_sensitivity, 15'b0}) +
                 $signed(msens_q[TERM_W-1:0]);
  end

  logic                     s3_valid;
  logic [RAW_W-1:0]         s3_d1;
  logic signed [TEMP_W-1:0] s3_temp1;
  logic [16:0]              s3_t2;
  logic signed [TERM_W-1:0] s3_off1, s3_sens1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  // dT*dT is never negative, so T2 is a plain shift
  always_ff @(posedge clk) begin
    s3_d1    <= s2_d1;
    s3_temp1 <= temp1_next;
    s3_t2    <= s2_mdd[47:31];
    s3_off1  <= off1_next;
    s3_sens1 <= sens1_next;
  end

  // ---------------- stage 4: squared deviations, range flags, final temperature
  logic signed [TEMP_W-1:0]   td, cd, temp2_next;
  logic signed [2*TEMP_W-1:0] tsq_full, csq_full;
  logic                       low_next, cold_next;

  always_comb begin
    td         = s3_temp1 - TEMP_BASE;
    cd         = s3_temp1 - TEMP_COLD;
    tsq_full   = td * td;
    csq_full   = cd * cd;
    low_next   = s3_temp1 < TEMP_BASE;
    cold_next  = s3_temp1 < TEMP_COLD;
    temp2_next = low_next ? s3_temp1 - $signed({3'b0, s3_t2}) : s3_temp1;
  end

  logic                     s4_valid;
  logic [RAW_W-1:0]         s4_d1;
  logic signed [TOUT_W-1:0] s4_temp;
  logic [SQ_W-1:0]          s4_tsq, s4_csq;
  logic                     s4_low, s4_cold;
  logic signed [TERM_W-1:0] s4_off1, s4_sens1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_d1    <= s3_d1;
    s4_temp  <= temp2_next[TOUT_W-1:0];
    s4_tsq   <= tsq_full[SQ_W-1:0];
    s4_csq   <= csq_full[SQ_W-1:0];
    s4_low   <= low_next;
    s4_cold  <= cold_next;
    s4_off1  <= s3_off1;
    s4_sens1 <= s3_sens1;
  end

  // ---------------- stage 5: second-order OFF2 and SENS2 (all non-negative)
  logic [CORR_W-1:0] tsq5, csq7, csq11, off2_next, sens2_next;

  always_comb begin
    tsq5  = {3'b0, s4_tsq} + {1'b0, s4_tsq, 2'b0};
    csq7  = {s4_csq, 3'b0} - {3'b0, s4_csq};
    csq11 = {s4_csq, 3'b0} + {2'b0, s4_csq, 1'b0} + {3'b0, s4_csq};
    off2_next  = '0;
    sens2_next = '0;
    if (s4_low) begin
      off2_next  = {1'b0, tsq5[CORR_W-1:1]} + (s4_cold ? csq7 : '0);
      sens2_next = {2'b0, tsq5[CORR_W-1:2]} +
                   (s4_cold ? {1'b0, csq11[CORR_W-1:1]} : '0);
    end
  end

  logic                     s5_valid;
  logic [RAW_W-1:0]         s5_d1;
  logic signed [TOUT_W-1:0] s5_temp;
  logic [CORR_W-1:0]        s5_off2, s5_sens2;
  logic signed [TERM_W-1:0] s5_off1, s5_sens1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_d1    <= s4_d1;
    s5_temp  <= s4_temp;
    s5_off2  <= off2_next;
    s5_sens2 <= sens2_next;
    s5_off1  <= s4_off1;
    s5_sens1 <= s4_sens1;
  end

  // ---------------- stage 6: corrected OFF and SENS
  logic                     s6_valid;
  logic [RAW_W-1:0]         s6_d1;
  logic signed [TOUT_W-1:0] s6_temp;
  logic signed [TERM_W-1:0] s6_off, s6_sens;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    s6_d1   <= s5_d1;
    s6_temp <= s5_temp;
    s6_off  <= s5_off1 - $signed({1'b0, s5_off2});
    s6_sens <= s5_sens1 - $signed({1'b0, s5_sens2});
  end

  assign front.valid = s6_valid;
  assign front.d1    = s6_d1;
  assign front.temp  = s6_temp;
  assign front.off   = s6_off;
  assign front.sens  = s6_sens;

endmodule

`default_nettype wire

@@ rtl/ptc_back.sv @@
// Pressure stages: split D1*SENS product, scaling and result registers.
`default_nettype none

module ptc_back import ptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  front_t                   front,
  output logic                     done,
  output logic signed [TOUT_W-1:0] temperature_centi,
  output logic signed [P_W-1:0]    pressure_pascal
);

  // ---------------- stage 7: D1*SENS as two 24x20 partial products
  logic                     s7_valid;
  logic signed [TOUT_W-1:0] s7_temp;
  logic signed [TERM_W-1:0] s7_off;
  logic [43:0]              s7_pp_lo;
  logic signed [44:0]       s7_pp_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= front.valid;
    end
  end

  always_ff @(posedge clk) begin
    s7_temp  <= front.temp;
    s7_off   <= front.off;
    s7_pp_lo <= front.d1 * front.sens[19:0];
    s7_pp_hi <= $signed({1'b0, front.d1}) * $signed(front.sens[TERM_W-1:20]);
  end

  // ---------------- stage 8: recombine the partial products
  logic signed [63:0]       prod_next;
  logic                     s8_valid;
  logic signed [TOUT_W-1:0] s8_temp;
  logic signed [TERM_W-1:0] s8_off;
  logic signed [63:0]       s8_prod;

  assign prod_next = $signed({s7_pp_hi[43:0], 20'b0}) + $signed({20'b0, s7_pp_lo});

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    s8_temp <= s7_temp;
    s8_off  <= s7_off;
    s8_prod <= prod_next;
  end

  // ---------------- stage 9: truncating divide by 2^21
  logic signed [63:0]       prod_adj, prod_q;
  logic                     s9_valid;
  logic signed [TOUT_W-1:0] s9_temp;
  logic signed [TERM_W-1:0] s9_off;
  logic signed [42:0]       s9_sterm;

  always_comb begin
    prod_adj = s8_prod + (s8_prod[63] ? 64'sd2097151 : 64'sd0);
    prod_q   = prod_adj >>> 21;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else begin
      s9_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    s9_temp  <= s8_temp;
    s9_off   <= s8_off;
    s9_sterm <= prod_q[42:0];
  end

  // ---------------- stage 10: subtract OFF, truncating divide by 2^15
  logic signed [43:0] diff, diff_adj, p_q;

  always_comb begin
    diff     = $signed({s9_sterm[42], s9_sterm}) - $signed({{4{s9_off[TERM_W-1]}}, s9_off});
    diff_adj = diff + (diff[43] ? 44'sd32767 : 44'sd0);
    p_q      = diff_adj >>> 15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    temperature_centi <= s9_temp;
    pressure_pascal   <= p_q[P_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/pressure_temp_compensation.sv @@
// Top level of the barometric pressure/temperature compensation pipeline.
//
//  channel  signals                               transfer
//  -------  ------------------------------------  ---------------------------------
//  command  start, busy, raw_pressure,            edge with start high, busy low
//           raw_temperature
//  result   done, temperature_centi,              every edge with done high
//           pressure_pascal
//  config   cfg_valid, cfg_ready, cfg_index,      edge with cfg_valid and cfg_ready
//           cfg_data
//
// Ten register stages; a sample may enter on every cycle while busy is low, and its
// result is strobed on done as it leaves the last stage. The depth is set by
// the chain of products of dT, the squared-deviation multipliers and the split
// 24x40 D1*SENS product. Synchronous reset clears every stage valid bit and
// the calibration words; busy is high only while rst is high. The result side
// is never stalled, so the pipeline advances every cycle.
`default_nettype none

module pressure_temp_compensation import ptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_W-1:0]         raw_pressure,
  input  logic [RAW_W-1:0]         raw_temperature,
  output logic                     done,
  output logic signed [TOUT_W-1:0] temperature_centi,
  output logic signed [P_W-1:0]    pressure_pascal,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CAL_W-1:0]         cfg_data
);

  cal_t   cal;
  front_t front;
  logic   in_valid;

  // Command transfer
  assign busy     = rst;
  assign in_valid = start && !busy;

  ptc_cal_regs u_cal_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  ptc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .cal             (cal),
    .front           (front)
  );

  ptc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .front             (front),
    .done              (done),
    .temperature_centi (temperature_centi),
    .pressure_pascal   (pressure_pascal)
  );

endmodule

`default_nettype wire

@@ rtl/ptc_checker.sv @@
// Port-level timing checks for the compensation pipeline, bound to the top level.
`default_nettype none

module ptc_checker import ptc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // No result straight after a reset edge
  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // Every command transfer yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after command transfer");

  // No result without a command transfer the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching command");

endmodule

bind pressure_temp_compensation ptc_checker u_ptc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire

@@ tb/compensation_checker.sv @@
// Checker for the pressure/temperature compensation block: predicts and compares results.
`timescale 1ns / 100ps

module compensation_checker import ptc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [RAW_W-1:0]         raw_pressure,
  input  logic [RAW_W-1:0]         raw_temperature,
  input  logic                     done,
  input  logic signed [TOUT_W-1:0] temperature_centi,
  input  logic signed [P_W-1:0]    pressure_pascal,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CAL_W-1:0]         cfg_data,
  output int                       errors,
  output int                       outstanding,
  output int                       samples,
  output int                       cool_samples,
  output int                       cold_samples
);

  // Truncating divisors of the compensation formulas
  localparam longint TEMP_DIV   = 64'sd8388608;
  localparam longint DEV_SQ_DIV = 64'sd2147483648;
  localparam longint OFF_DIV    = 64'sd128;
  localparam longint SENS_DIV   = 64'sd256;
  localparam longint PMUL_DIV   = 64'sd2097152;
  localparam longint PFIN_DIV   = 64'sd32768;

  typedef struct {
    logic signed [TOUT_W-1:0] temp;
    logic signed [P_W-1:0]    press;
  } reading_t;

  reading_t readings_due[$];
  cal_t     cal_words;

  // Second-order compensation in 64-bit signed arithmetic; divisions truncate
  function automatic void compensate(
    input  logic [RAW_W-1:0]         d1_raw,
    input  logic [RAW_W-1:0]         d2_raw,
    input  cal_t                     c,
    output logic signed [TOUT_W-1:0] temp_out,
    output logic signed [P_W-1:0]    press_out,
    output longint                   first_temp
  );
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, t2, off2, sens2, off, sens, dev, dev_sq, cold_dev, cold_sq, p;
    d1 = d1_raw;
    d2 = d2_raw;
    c1 = c.pressure_sensitivity;
    c2 = c.pressure_offset;
    c3 = c.sensitivity_temp_coeff;
    c4 = c.offset_temp_coeff;
    c5 = c.reference_temperature;
    c6 = c.temperature_slope;
    t2 = 0;
    off2 = 0;
    sens2 = 0;

    dt = d2 - c5 * 64'sd256;
    temp = TEMP_BASE + (dt * c6) / TEMP_DIV;
    first_temp = temp;

    // below 20 C: second-order terms; below -15 C: the extra cold term
    if (temp < TEMP_BASE) begin
      dev = temp - TEMP_BASE;
      dev_sq = dev * dev;
      t2 = (dt * dt) / DEV_SQ_DIV;
      off2 = (64'sd5 * dev_sq) / 64'sd2;
      sens2 = (64'sd5 * dev_sq) / 64'sd4;
      if (temp < TEMP_COLD) begin
        cold_dev = temp - TEMP_COLD;
        cold_sq = cold_dev * cold_dev;
        off2 = off2 + 64'sd7 * cold_sq;
        sens2 = sens2 + (64'sd11 * cold_sq) / 64'sd2;
      end
    end
    temp = temp - t2;

    off = c2 * 64'sd65536 + (c4 * dt) / OFF_DIV - off2;
    sens = c1 * 64'sd32768 + (c3 * dt) / SENS_DIV - sens2;
    p = ((d1 * sens) / PMUL_DIV - off) / PFIN_DIV;

    temp_out = temp[TOUT_W-1:0];
    press_out = p[P_W-1:0];
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin : watch
    reading_t due, fresh;
    longint   first_temp;
    int       bad;
    bad = 0;
    if (rst) begin
      cal_words <= '0;
      readings_due.delete();
      errors <= 0;
      outstanding <= 0;
      samples <= 0;
      cool_samples <= 0;
      cold_samples <= 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (done) begin
        if (readings_due.size() == 0) begin
          bad++;
          $display("%0t: result with nothing expected: temp %0d pressure %0d",
                   $time, temperature_centi, pressure_pascal);
        end else begin
          due = readings_due.pop_front();
          if (temperature_centi !== due.temp) begin
            bad++;
            $display("%0t: temperature_centi expected %0d got %0d",
                     $time, due.temp, temperature_centi);
          end
          if (pressure_pascal !== due.press) begin
            bad++;
            $display("%0t: pressure_pascal expected %0d got %0d",
                     $time, due.press, pressure_pascal);
          end
        end
      end

      // sample transfer: predict its reading
      if (start && !busy) begin
        compensate(raw_pressure, raw_temperature, cal_words, fresh.temp, fresh.press,
                   first_temp);
        readings_due.push_back(fresh);
        samples <= samples + 1;
        if (first_temp < TEMP_BASE)
          cool_samples <= cool_samples + 1;
        if (first_temp < TEMP_COLD)
          cold_samples <= cold_samples + 1;
      end

      // calibration write; spare indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRESSURE_SENSITIVITY:   cal_words.pressure_sensitivity <= cfg_data;
          REG_PRESSURE_OFFSET:        cal_words.pressure_offset <= cfg_data;
          REG_SENSITIVITY_TEMP_COEFF: cal_words.sensitivity_temp_coeff <= cfg_data;
          REG_OFFSET_TEMP_COEFF:      cal_words.offset_temp_coeff <= cfg_data;
          REG_REFERENCE_TEMPERATURE:  cal_words.reference_temperature <= cfg_data;
          REG_TEMPERATURE_SLOPE:      cal_words.temperature_slope <= cfg_data;
          default: ;
        endcase
      end

      errors <= errors + bad;
      outstanding <= readings_due.size();
    end
  end

endmodule

@@ tb/pressure_temp_compensation_tb.sv @@
// Testbench top for the pressure/temperature compensation block: stimulus and verdict.
`timescale 1ns / 100ps

module pressure_temp_compensation_tb;
  import ptc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 312;

  // Indexes past the last calibration word
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Calibration sets: C1..C6 in field order
  localparam cal_t CAL_TYPICAL = {16'd40127, 16'd36924, 16'd23317,
                                  16'd23282, 16'd33464, 16'd28312};
  localparam cal_t CAL_ALL_ONES = {6{16'hFFFF}};
  localparam cal_t CAL_MIXED = {16'h0000, 16'hFFFF, 16'hFFFF,
                                16'h0000, 16'hFFFF, 16'hFFFF};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [RAW_W-1:0]         raw_pressure = '0;
  logic [RAW_W-1:0]         raw_temperature = '0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CAL_W-1:0]         cfg_data = '0;
  logic                     busy;
  logic                     done;
  logic                     cfg_ready;
  logic signed [TOUT_W-1:0] temperature_centi;
  logic signed [P_W-1:0]    pressure_pascal;

  int errors, outstanding, samples, cool_samples, cold_samples;
  int idle_cycles = 0;
  int cal_sets = 0;

  always #5 clk = ~clk;

  pressure_temp_compensation dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .raw_pressure      (raw_pressure),
    .raw_temperature   (raw_temperature),
    .done              (done),
    .temperature_centi (temperature_centi),
    .pressure_pascal   (pressure_pascal),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  compensation_checker check_i (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .raw_pressure      (raw_pressure),
    .raw_temperature   (raw_temperature),
    .done              (done),
    .temperature_centi (temperature_centi),
    .pressure_pascal   (pressure_pascal),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .errors            (errors),
    .outstanding       (outstanding),
    .samples           (samples),
    .cool_samples      (cool_samples),
    .cold_samples      (cold_samples)
  );

  // Watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("pressure_temp_compensation regression: fail");
    $finish;
  end

  // One calibration write; valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_cal(input cal_t c);
    write_reg(REG_PRESSURE_SENSITIVITY, c.pressure_sensitivity);
    write_reg(REG_PRESSURE_OFFSET, c.pressure_offset);
    write_reg(REG_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
    write_reg(REG_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
    write_reg(REG_REFERENCE_TEMPERATURE, c.reference_temperature);
    write_reg(REG_TEMPERATURE_SLOPE, c.temperature_slope);
    cfg_valid <= 1'b0;
    cal_sets++;
  endtask

  // Wait until every predicted reading has come back
  task automatic wait_drained;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // One sample transfer, after a random number of idle cycles
  task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                             input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    raw_pressure <= d1;
    raw_temperature <= d2;
    do @(posedge clk); while (busy);
  endtask

  function automatic cal_t random_cal();
    cal_t c;
    c = {$urandom, $urandom, $urandom};
    return c;
  endfunction

  // Raw temperature: mostly near the reference point, so that all bands are hit
  function automatic logic [RAW_W-1:0] pick_temperature(input cal_t c);
    logic [RAW_W-1:0] d2;
    int unsigned      k;
    longint           centre, span, v;
    d2 = RAW_W'($urandom);
    k = $urandom_range(RAW_W - 1, 0);
    centre = longint'(c.reference_temperature) * 256;
    span = longint'($urandom & ((32'd1 << k) - 1));
    v = $urandom_range(1) ? centre + span : centre - span;
    if (v < 0)
      v = 0;
    if (v > 64'sd16777215)
      v = 64'sd16777215;
    if ($urandom_range(9) >= 4)
      d2 = v[RAW_W-1:0];
    return d2;
  endfunction

  task automatic run_phase(input cal_t c, input int idle_pct, input bit drain_midway);
    logic [RAW_W-1:0] d1;
    wait_drained;
    load_cal(c);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (drain_midway && i == PHASE_ITEMS / 2) begin
        start <= 1'b0;
        wait_drained;
      end
      d1 = RAW_W'($urandom);
      send_sample(d1, pick_temperature(c), idle_pct);
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero calibration words as left by reset
    send_sample('0, '0, 0);
    send_sample('1, '1, 0);
    send_sample(24'h5A5A5A, 24'hA5A5A5, 0);
    start <= 1'b0;
    wait_drained;

    // writes to spare indexes must leave the calibration alone
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h5A5A);
    load_cal(CAL_TYPICAL);

    // field extremes, the 20 C edge and the -15 C edge
    send_sample('0, '0, 0);
    send_sample('1, '0, 0);
    send_sample('0, '1, 0);
    send_sample('1, '1, 0);
    send_sample(24'hAAAAAA, 24'h555555, 0);
    send_sample(24'h555555, 24'hAAAAAA, 0);
    send_sample(24'd9085466, 24'd8566784, 0);
    send_sample(24'd9085466, 24'd8566488, 0);
    send_sample(24'd9085466, 24'd8566487, 0);
    send_sample(24'd9085466, 24'd8566192, 0);
    send_sample(24'd9085466, 24'd16555392, 0);
    send_sample(24'd9085466, 24'd7530066, 0);
    send_sample(24'd9085466, 24'd7529766, 0);
    send_sample(24'd9085466, 24'd7529466, 0);
    send_sample(24'd1, 24'd1000000, 0);
    send_sample(24'd16777214, 24'd3000000, 0);
    start <= 1'b0;

    run_phase(CAL_ALL_ONES, 0, 1'b0);
    run_phase(CAL_TYPICAL, 69, 1'b1);
    run_phase(random_cal(), 14, 1'b0);
    run_phase(CAL_MIXED, 0, 1'b0);
    run_phase(random_cal(), 69, 1'b0);
    run_phase(random_cal(), 14, 1'b0);

    wait_drained;
    repeat (LATENCY + 4) @(posedge clk);

    $display("Covered %0d samples under %0d calibration sets (zero set included).",
             samples, cal_sets + 1);
    $display("Second-order band hit by %0d samples, extra cold term by %0d.",
             cool_samples, cold_samples);
    if (errors == 0 && outstanding == 0)
      $display("pressure_temp_compensation regression: pass");
    else
      $display("pressure_temp_compensation regression: fail");
    $finish;
  end

endmodule
